/* hw/rtl/rfae_pkg.sv */
// Shared types and constants for the register file ALU executor.
// Used by rfae_front, rfae_fifo, rfae_back and the top level.
package rfae_pkg;

  localparam int NUM_REGS   = 4;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(NUM_REGS);
  localparam int Q_DEPTH    = 2;
  localparam int DIV_CNT_W  = $clog2(DATA_WIDTH + 1);

  typedef enum logic [3:0] {
    CMD_IN   = 4'd0,
    CMD_MOV  = 4'd1,
    CMD_XCHG = 4'd2,
    CMD_ADD  = 4'd3,
    CMD_SUB  = 4'd4,
    CMD_MUL  = 4'd5,
    CMD_DIV  = 4'd6,
    CMD_MOD  = 4'd7,
    CMD_AND  = 4'd8,
    CMD_OR   = 4'd9,
    CMD_XOR  = 4'd10,
    CMD_OUT  = 4'd11
  } cmd_t;

  // Decoded word handed from the front to the back.
  typedef struct packed {
    cmd_t                   cmd;
    logic [IDX_W-1:0]       dest;
    logic [IDX_W-1:0]       src_x;
    logic [IDX_W-1:0]       src_y;
    logic [DATA_WIDTH-1:0]  imm;
  } op_t;

endpackage

/* hw/rtl/rfae_front.sv */
// Front end: accept input words, drop undefined commands, pick operands.
// Depends on rfae_pkg.
module rfae_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           cmd,
  input  logic [1:0]           dest_index,
  input  logic [1:0]           src_a_index,
  input  logic [1:0]           src_b_index,
  input  logic                 three_operand,
  input  logic signed [31:0]   immediate,
  output logic                 op_valid,
  input  logic                 op_ready,
  output rfae_pkg::op_t        op
);
  import rfae_pkg::*;

  logic  ok;
  op_t   op_next;

  // Hold one decoded word; take a new one when empty or draining
  assign in_ready = !op_valid || op_ready;
  assign ok = (cmd <= 4'(CMD_OUT));

  always_comb begin
    op_next.cmd  = cmd_t'(cmd);
    op_next.dest = IDX_W'(dest_index % NUM_REGS);
    op_next.imm  = DATA_WIDTH'(immediate);
    if (three_operand && cmd >= 4'(CMD_ADD) && cmd <= 4'(CMD_XOR)) begin
      op_next.src_x = IDX_W'(src_a_index % NUM_REGS);
      op_next.src_y = IDX_W'(src_b_index % NUM_REGS);
    end else if (cmd >= 4'(CMD_ADD) && cmd <= 4'(CMD_XOR)) begin
      op_next.src_x = IDX_W'(dest_index % NUM_REGS);
      op_next.src_y = IDX_W'(src_a_index % NUM_REGS);
    end else begin
      op_next.src_x = IDX_W'(dest_index % NUM_REGS);
      op_next.src_y = IDX_W'(src_a_index % NUM_REGS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (in_ready) begin
      op_valid <= in_valid && ok;
    end
    if (in_ready) begin
      op <= op_next;
    end
  end

  // Undefined commands never reach the queue
  a_cmd_ok: assert property (@(posedge clk) disable iff (rst)
    op_valid |-> op.cmd <= CMD_OUT) else $error("bad cmd forwarded");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    op_valid && !op_ready |=> op_valid && $stable(op)) else $error("word lost");
  a_drop: assert property (@(posedge clk) disable iff (rst)
    in_ready && !in_valid |=> !op_valid) else $error("word invented");

endmodule

/* hw/rtl/rfae_fifo.sv */
// Short queue of decoded words between front and back.
// Depends on rfae_pkg.
module rfae_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  rfae_pkg::op_t  wr_op,
  output logic           rd_valid,
  input  logic           rd_ready,
  output rfae_pkg::op_t  rd_op
);
  import rfae_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  op_t           mem [Q_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != (PW+1)'(Q_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_op    = mem[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
    if (push) begin
      mem[wp] <= wr_op;
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(Q_DEPTH)) else $error("queue overflow");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == (PW+1)'(Q_DEPTH)) |-> wp == rp) else $error("ptr skew");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1) else $error("pop count");

endmodule

/* hw/rtl/rfae_back.sv */
// Back end: register file, ALU, iterative divider and result register.
// Depends on rfae_pkg.
module rfae_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  output logic                 op_ready,
  input  rfae_pkg::op_t        op,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   value,
  output logic                 divide_by_zero
);
  import rfae_pkg::*;

  localparam int W = DATA_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

  state_t               state;
  logic [W-1:0]         rf [NUM_REGS];
  logic [W-1:0]         x;
  logic [W-1:0]         y;
  logic [W-1:0]         prod;
  logic [W-1:0]         quo;
  logic [W-1:0]         rem;
  logic [W-1:0]         dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg_q;
  logic                 neg_r;
  logic                 is_mod;
  logic [IDX_W-1:0]     dst;
  logic [W:0]           trial;
  logic [W-1:0]         rem_sh;
  logic                 take;
  logic                 res_free;
  logic                 res_load;

  assign x        = rf[op.src_x];
  assign y        = rf[op.src_y];
  assign res_free = !out_valid || out_ready;
  assign take     = (state == S_IDLE) && op_valid && res_free;
  assign op_ready = take;

  // Load the result register on OUT and on a zero divisor
  assign res_load = take && ((op.cmd == CMD_OUT) ||
                    (((op.cmd == CMD_DIV) || (op.cmd == CMD_MOD)) && (y == '0)));

  // One restoring step: shift in next dividend bit, trial subtract
  assign rem_sh = {rem[W-2:0], quo[W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) rf[i] <= '0;
    end else begin
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            dst <= op.dest;
            case (op.cmd)
              CMD_IN:   rf[op.dest] <= op.imm;
              CMD_MOV:  rf[op.dest] <= y;
              CMD_XCHG: begin
                rf[op.dest] <= y;
                if (op.dest != op.src_y) rf[op.src_y] <= x;
              end
              CMD_ADD:  rf[op.dest] <= x + y;
              CMD_SUB:  rf[op.dest] <= x - y;
              CMD_AND:  rf[op.dest] <= x & y;
              CMD_OR:   rf[op.dest] <= x | y;
              CMD_XOR:  rf[op.dest] <= x ^ y;
              CMD_MUL: begin
                prod  <= x * y;
                state <= S_MUL;
              end
              CMD_DIV, CMD_MOD: begin
                if (y == '0) begin
                  value          <= '0;
                  divide_by_zero <= 1'b1;
                end else begin
                  quo    <= x[W-1] ? -x : x;
                  dvs    <= y[W-1] ? -y : y;
                  rem    <= '0;
                  neg_q  <= x[W-1] ^ y[W-1];
                  neg_r  <= x[W-1];
                  is_mod <= (op.cmd == CMD_MOD);
                  cnt    <= DIV_CNT_W'(W);
                  state  <= S_DIV;
                end
              end
              CMD_OUT: begin
                value          <= 32'(signed'(rf[op.dest]));
                divide_by_zero <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          rf[dst] <= prod;
          state   <= S_IDLE;
        end
        S_DIV: begin
          if (!trial[W]) begin
            rem <= trial[W-1:0];
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[W-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == DIV_CNT_W'(1)) state <= S_DONE;
        end
        S_DONE: begin
          if (is_mod) rf[dst] <= neg_r ? -rem : rem;
          else        rf[dst] <= neg_q ? -quo : quo;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready: assert property (@(posedge clk) disable iff (rst)
    op_ready |-> state == S_IDLE) else $error("ready while busy");
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && cnt == DIV_CNT_W'(1) |=> state == S_DONE) else $error("div count");
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> value == '0) else $error("dz value");

endmodule

/* hw/rtl/register_file_alu_executor.sv */
// Top level: front decode, word queue, back execution.
// Depends on rfae_pkg, rfae_front, rfae_fifo, rfae_back.
//
//  port group   dir  handshake            payload
//  input word   in   in_valid/in_ready    cmd, dest_index, src_a_index,
//                                         src_b_index, three_operand, immediate
//  result word  out  out_valid/out_ready  value, divide_by_zero
//
// IN, MOV, XCHG, ADD, SUB, logic ops and OUT finish in the idle state; MUL
// goes through the multiply register, then write back; DIV and MOD with a
// nonzero divisor: setup, 32 one-bit-per-cycle divider steps, write back.
// Reset (rst, synchronous) clears the registers and empties the queue.
// The front keeps taking words while the back is busy, until the queue fills.
module register_file_alu_executor (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          cmd,
  input  logic [1:0]          dest_index,
  input  logic [1:0]          src_a_index,
  input  logic [1:0]          src_b_index,
  input  logic                three_operand,
  input  logic signed [31:0]  immediate,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  value,
  output logic                divide_by_zero
);
  import rfae_pkg::*;

  logic f_valid, f_ready, q_valid, q_ready;
  op_t  f_op, q_op;

  rfae_front u_front (
    .clk, .rst, .in_valid, .in_ready, .cmd, .dest_index, .src_a_index,
    .src_b_index, .three_operand, .immediate,
    .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
  );

  rfae_fifo u_fifo (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_op(f_op),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_op(q_op)
  );

  rfae_back u_back (
    .clk, .rst, .op_valid(q_valid), .op_ready(q_ready), .op(q_op),
    .out_valid, .out_ready, .value, .divide_by_zero
  );

endmodule

/* dv/register_file_alu_executor_test.sv */
// Testbench for the register file ALU executor: drives random instruction words,
// predicts OUT and divide-by-zero results from a shadow register file.
// Depends on rfae_pkg and register_file_alu_executor.
`timescale 1ns / 100ps

module register_file_alu_executor_test;
  import rfae_pkg::*;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [1:0]         dest;
    logic [1:0]         src_a;
    logic [1:0]         src_b;
    logic               three;
    logic signed [31:0] imm;
  } instr_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               dbz;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] cmd = '0;
  logic [1:0] dest_index = '0;
  logic [1:0] src_a_index = '0;
  logic [1:0] src_b_index = '0;
  logic three_operand = 1'b0;
  logic signed [31:0] immediate = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] value;
  logic divide_by_zero;

  instr_t pending_words[$];
  reply_t expected_replies[$];
  logic signed [31:0] shadow_regs[4];
  int mismatches = 0;
  bit stim_done = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_cycles = 0;
  int accepted = 0;

  register_file_alu_executor i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one accepted word to the shadow file; queue any reply it causes.
  task automatic execute_word(input instr_t w);
    logic signed [31:0] x, y, r;
    logic [31:0] ux, uy, q, rm;
    logic nx, ny;
    x = w.three ? shadow_regs[w.src_a] : shadow_regs[w.dest];
    y = w.three ? shadow_regs[w.src_b] : shadow_regs[w.src_a];
    case (w.cmd)
      CMD_IN: shadow_regs[w.dest] = w.imm;
      CMD_MOV: shadow_regs[w.dest] = shadow_regs[w.src_a];
      CMD_XCHG: begin
        r = shadow_regs[w.dest];
        shadow_regs[w.dest] = shadow_regs[w.src_a];
        shadow_regs[w.src_a] = r;
      end
      CMD_OUT: expected_replies.push_back('{val: shadow_regs[w.dest], dbz: 1'b0});
      CMD_ADD: shadow_regs[w.dest] = x + y;
      CMD_SUB: shadow_regs[w.dest] = x - y;
      CMD_MUL: shadow_regs[w.dest] = x * y;
      CMD_AND: shadow_regs[w.dest] = x & y;
      CMD_OR:  shadow_regs[w.dest] = x | y;
      CMD_XOR: shadow_regs[w.dest] = x ^ y;
      CMD_DIV, CMD_MOD: begin
        if (y == 0) begin
          expected_replies.push_back('{val: 32'sd0, dbz: 1'b1});
        end else begin
          // Divide magnitudes, then restore signs (truncate toward zero).
          nx = x[31];
          ny = y[31];
          ux = nx ? -x : x;
          uy = ny ? -y : y;
          q = ux / uy;
          rm = ux % uy;
          if (w.cmd == CMD_DIV) shadow_regs[w.dest] = (nx != ny) ? -q : q;
          else shadow_regs[w.dest] = nx ? -rm : rm;
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      4: return $signed(32'($urandom_range(0, 20))) - 10;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic instr_t make_word(input logic [3:0] c, input logic [1:0] d,
                                       input logic [1:0] a, input logic [1:0] b,
                                       input logic t, input logic signed [31:0] v);
    instr_t w;
    w.cmd = c; w.dest = d; w.src_a = a; w.src_b = b; w.three = t; w.imm = v;
    return w;
  endfunction

  // Fill the word queue: directed corner cases first, then random programs.
  initial begin
    int n;
    pending_words.push_back(make_word(CMD_OUT, 2'd3, 2'd0, 2'd0, 1'b0, 32'sd0));
    pending_words.push_back(make_word(CMD_IN, 2'd0, 2'd3, 2'd3, 1'b1, 32'sh8000_0000));
    pending_words.push_back(make_word(CMD_IN, 2'd1, 2'd0, 2'd0, 1'b0, -32'sd1));
    pending_words.push_back(make_word(CMD_IN, 2'd2, 2'd0, 2'd0, 1'b0, 32'sh7fff_ffff));
    pending_words.push_back(make_word(CMD_DIV, 2'd3, 2'd0, 2'd1, 1'b1, 32'sd0));
    pending_words.push_back(make_word(CMD_MOD, 2'd2, 2'd0, 2'd1, 1'b1, 32'sd0));
    pending_words.push_back(make_word(CMD_OUT, 2'd3, 2'd0, 2'd0, 1'b0, 32'sd0));
    pending_words.push_back(make_word(CMD_OUT, 2'd2, 2'd0, 2'd0, 1'b0, 32'sd0));
    pending_words.push_back(make_word(CMD_DIV, 2'd0, 2'd3, 2'd0, 1'b0, 32'sd0));
    pending_words.push_back(make_word(CMD_MOD, 2'd0, 2'd3, 2'd0, 1'b1, 32'sd0));
    pending_words.push_back(make_word(CMD_XCHG, 2'd1, 2'd1, 2'd2, 1'b1, 32'sd0));
    pending_words.push_back(make_word(CMD_XCHG, 2'd1, 2'd2, 2'd0, 1'b0, 32'sd0));
    pending_words.push_back(make_word(CMD_MOV, 2'd3, 2'd1, 2'd2, 1'b1, -32'sd1));
    for (int c = CMD_ADD; c <= CMD_XOR; c++) begin
      pending_words.push_back(make_word(4'(c), 2'd0, 2'd1, 2'd2, 1'b1, 32'sd0));
      pending_words.push_back(make_word(4'(c), 2'd3, 2'd2, 2'd1, 1'b0, 32'sd0));
    end
    pending_words.push_back(make_word(4'd12, 2'd0, 2'd0, 2'd0, 1'b0, 32'sd5));
    pending_words.push_back(make_word(4'd15, 2'd3, 2'd3, 2'd3, 1'b1, -32'sd1));
    for (int r = 0; r < 4; r++)
      pending_words.push_back(make_word(CMD_OUT, 2'(r), 2'd0, 2'd0, 1'b0, 32'sd0));
    // Random programs: mostly valid commands with frequent reads back.
    n = 0;
    while (n < 750) begin
      instr_t w;
      w.dest = 2'($urandom);
      w.src_a = 2'($urandom);
      w.src_b = 2'($urandom);
      w.three = 1'($urandom);
      w.imm = pick_value();
      case ($urandom_range(0, 9))
        0, 1: w.cmd = CMD_IN;
        2, 3: w.cmd = CMD_OUT;
        4: w.cmd = 4'($urandom_range(12, 15));
        5: w.cmd = $urandom_range(0, 1) ? CMD_DIV : CMD_MOD;
        default: w.cmd = 4'($urandom_range(1, 10));
      endcase
      if (w.cmd == CMD_DIV || w.cmd == CMD_MOD) begin
        if ($urandom_range(0, 3) != 0)
          pending_words.push_back(make_word(CMD_IN, w.three ? w.src_b : w.src_a,
                                            2'd0, 2'd0, 1'b0, pick_value()));
      end
      pending_words.push_back(w);
      if (w.cmd < 4'd12) n++;
    end
    stim_done = 1'b1;
  end

  // Drive words in bursts separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        execute_word({cmd, dest_index, src_a_index, src_b_index, three_operand, immediate});
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          instr_t w;
          w = pending_words.pop_front();
          {cmd, dest_index, src_a_index, src_b_index, three_operand, immediate} <= w;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side; hold off for a long stretch once, mid-run.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (accepted > 300 && accepted < 340) begin
      hold_cycles++;
      out_ready <= (hold_cycles > 400);
    end else begin
      case ((accepted / 128) % 3)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: value %0d dbz %0b",
                                       value, divide_by_zero);
      end else begin
        reply_t e;
        e = expected_replies.pop_front();
        if (e.val !== value || e.dbz !== divide_by_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected value %0d dbz %0b, got value %0d dbz %0b",
                     e.val, e.dbz, value, divide_by_zero);
        end
      end
    end
  end

  initial begin
    for (int r = 0; r < 4; r++) shadow_regs[r] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && pending_words.size() == 0 && !in_valid);
    wait (expected_replies.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
